FILE: src/ssq_pkg.sv
// Shared types and constants for the subset-sum query block.
// No dependencies; every other file in src/ except ssq_ram imports this package.
package ssq_pkg;

  // Limits of the loaded set
  localparam int MAX_ITEMS = 32;
  localparam int MAX_VALUE = 2047;
  localparam int MAX_SUM   = 65535;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 16;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 6;

  // Reachable-sum bitmap: 65536 bits kept as 1024 words of 64
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = 1024;
  localparam int WADDR_W = $clog2(WORDS);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // What an accepted beat turns into
  typedef enum logic [1:0] {
    K_DONE  = 2'd0,
    K_ADD   = 2'd1,
    K_QUERY = 2'd2,
    K_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_INIT      = 3'd0,
    S_IDLE      = 3'd1,
    S_ADD_PRIME = 3'd2,
    S_ADD_RUN   = 3'd3,
    S_ADD_DRAIN = 3'd4,
    S_Q_READ    = 3'd5,
    S_Q_WAIT    = 3'd6,
    S_FINISH    = 3'd7
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic              found;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;
    logic add_prime;
    logic add_step;
    logic clr_step;
    logic q_read;
    logic q_capture;
    logic load_result;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    kind_e in_kind;
    logic  last_add;
    logic  last_clr;
    logic  slot_free;
  } dp_stat_t;

endpackage

FILE: src/subset_sum_query_core.sv
// Top level of the subset-sum query block.
// Depends on ssq_pkg, ssq_ctrl, ssq_datapath (and ssq_ram below it).
//
// Keeps a 65536-bit map of reachable subset sums (1024 words of 64 bits in
// a RAM with one write and two registered read ports). Bit s is set when
// some subset of the loaded values adds to s; after reset or a clear only
// sum zero is set. Every accepted input beat yields exactly one output beat
// {found, status}. An add of value v sweeps the map from the top word down
// to word v/64, one word per cycle, ORing each word with the map shifted up
// by v. A query reads one word. A clear rewrites all 1024 words. A rejected
// add, a query out of range and the unused request code go straight to the
// result without touching the map. The word sweep through the single write
// port sets the add and clear times. After reset the same sweep initializes
// the map, so in_ready stays low until that sweep ends. One beat is worked
// on at a time; a finished result waits in the output register while the
// next beat is accepted, and a following result waits until that register
// is taken. Adds beyond 32 accepted values return status 1 (set full); an
// add of 0 or above 2047, or a query of 0, returns status 2 (value out of
// range) with found 0.
module subset_sum_query_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssq_pkg::out_beat_t out_data
);
  import ssq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing only; no payload passes through the controller
  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap, counters and the output register
  ssq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/ssq_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
module ssq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/ssq_datapath.sv
// Datapath: bitmap RAM, sweep counter, shift-OR word update, item count,
// result register. Depends on ssq_pkg and ssq_ram.
module ssq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ssq_pkg::in_beat_t  in_data,
  input  ssq_pkg::ctrl_cmd_t cmd,
  output ssq_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output ssq_pkg::out_beat_t out_data
);
  import ssq_pkg::*;

  logic [VALUE_W-1:0]  val_q;
  status_e             status_q;
  logic                found_q;
  logic [CNT_W-1:0]    item_count;
  logic [WADDR_W-1:0]  dst;
  logic [WADDR_W-1:0]  ws;
  logic [BIT_W-1:0]    bs;
  logic [WORD_W-1:0]   prev;
  logic                w_valid;
  logic [WADDR_W-1:0]  w_addr;
  logic                w_lo_zero;

  kind_e               in_kind;
  status_e             in_status;

  logic                ram_we;
  logic [WADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WADDR_W-1:0]  raddr_a;
  logic [WADDR_W-1:0]  raddr_b;
  logic [WORD_W-1:0]   rdata_a;
  logic [WORD_W-1:0]   rdata_b;
  logic [WORD_W-1:0]   lo_word;
  logic [2*WORD_W-1:0] pair_shifted;

  // word and bit offset of the value being added
  assign ws = val_q[VALUE_W-1:BIT_W];
  assign bs = val_q[BIT_W-1:0];

  // classify the beat on the input port
  always_comb begin
    in_kind   = K_DONE;
    in_status = ST_OK;
    case (in_data.req_type)
      REQ_ADD: begin
        if (in_data.value == '0 || in_data.value > VALUE_W'(MAX_VALUE)) begin
          in_status = ST_RANGE;
        end else if (item_count >= CNT_W'(MAX_ITEMS)) begin
          in_status = ST_FULL;
        end else begin
          in_kind = K_ADD;
        end
      end
      REQ_QUERY: begin
        if (in_data.value == '0 || in_data.value > VALUE_W'(MAX_SUM)) begin
          in_status = ST_RANGE;
        end else begin
          in_kind = K_QUERY;
        end
      end
      REQ_CLEAR: begin
        in_kind = K_CLEAR;
      end
      default: ;
    endcase
  end

  assign stat.in_kind   = in_kind;
  assign stat.last_add  = (dst == ws);
  assign stat.last_clr  = (dst == '0);
  assign stat.slot_free = !out_valid || out_ready;

  // read ports: A reads the destination word (or the query word),
  // B runs one word below the source window
  assign raddr_a = cmd.q_read ? val_q[VALUE_W-1:BIT_W] : dst;
  assign raddr_b = cmd.add_prime ? (WADDR_W'(WORDS - 1) - ws)
                                 : (dst - ws - WADDR_W'(1));

  // new = old | {hi, lo} shifted up by bs, upper half
  assign lo_word      = w_lo_zero ? '0 : rdata_b;
  assign pair_shifted = {prev, lo_word} << bs;

  always_comb begin
    ram_we    = w_valid || cmd.clr_step;
    ram_waddr = w_valid ? w_addr : dst;
    if (w_valid) begin
      ram_wdata = rdata_a | pair_shifted[2*WORD_W-1:WORD_W];
    end else begin
      ram_wdata = (dst == '0) ? WORD_W'(1) : '0;
    end
  end

  ssq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_bitmap (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      dst        <= WADDR_W'(WORDS - 1);
      item_count <= '0;
      w_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        dst <= WADDR_W'(WORDS - 1);
      end else if (cmd.add_step || cmd.clr_step) begin
        dst <= dst - WADDR_W'(1);
      end
      if (cmd.latch && in_kind == K_ADD) begin
        item_count <= item_count + CNT_W'(1);
      end else if (cmd.latch && in_kind == K_CLEAR) begin
        item_count <= '0;
      end
      w_valid <= cmd.add_step;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prev      <= rdata_b;
    w_addr    <= dst;
    w_lo_zero <= (dst == ws);
    if (cmd.latch) begin
      val_q    <= in_data.value;
      status_q <= in_status;
      found_q  <= 1'b0;
    end else if (cmd.q_capture) begin
      found_q <= rdata_a[bs];
    end
    if (cmd.load_result) begin
      out_data.found  <= found_q;
      out_data.status <= status_q;
    end
  end

endmodule

FILE: src/ssq_ctrl.sv
// Controller FSM: sequences the bitmap clear, add sweep and query read.
// Depends on ssq_pkg.
module ssq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssq_pkg::dp_stat_t  stat,
  output ssq_pkg::ctrl_cmd_t cmd
);
  import ssq_pkg::*;

  state_e state;
  state_e state_next;

  // set while the sweep was started by a clear beat rather than by reset
  logic clr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.last_clr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (stat.in_kind)
            K_ADD:   state_next = S_ADD_PRIME;
            K_QUERY: state_next = S_Q_READ;
            K_CLEAR: state_next = S_INIT;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_ADD_PRIME: begin
        cmd.add_prime = 1'b1;
        state_next    = S_ADD_RUN;
      end
      S_ADD_RUN: begin
        cmd.add_step = 1'b1;
        if (stat.last_add) begin
          state_next = S_ADD_DRAIN;
        end
      end
      S_ADD_DRAIN: begin
        state_next = S_FINISH;
      end
      S_Q_READ: begin
        cmd.q_read = 1'b1;
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        cmd.q_capture = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a clear beat reuses the reset sweep but still owes a result
    if (state == S_INIT && stat.last_clr && clr_item) begin
      state_next = S_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_item <= 1'b0;
    end else if (cmd.latch) begin
      clr_item <= (stat.in_kind == K_CLEAR);
    end else if (state == S_INIT && stat.last_clr) begin
      clr_item <= 1'b0;
    end
  end

endmodule

FILE: src/ssq_checker.sv
// Port-level checks for subset_sum_query_core, bound onto the top level.
// Depends on ssq_pkg.
module ssq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input ssq_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ssq_pkg::out_beat_t out_data
);
  import ssq_pkg::*;

  // beats accepted whose result has not yet been taken
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("handshake active right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result with no accepted beat behind it");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == ST_OK)
    else $error("found set on a rejected beat");

endmodule

bind subset_sum_query_core ssq_checker u_ssq_checker (.*);

FILE: tb/sv/tb_subset_sum_query_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for subset_sum_query_core: directed edge cases, then
// random add/query/clear sequences under several idle and stall phases.
// Depends on ssq_pkg and the subset_sum_query_core RTL.
module tb_subset_sum_query_core;
  import ssq_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;  // cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES = 1100;   // longest beat latency plus margin
  localparam int unsigned MAX_REPORTS = 10;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  subset_sum_query_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow of the block: reachable-sum map, accepted add count, and the
  // values behind the count (used only to aim query targets).
  bit [65535:0]  sum_map;
  int unsigned   n_loaded;
  int unsigned   loaded_vals[$];

  out_beat_t     pending_answers[$];
  int unsigned   mismatches;
  int unsigned   useful_sent;
  int unsigned   quiet_cycles;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected answer for one accepted request; updates the shadow state.
  function automatic out_beat_t predict_answer(in_beat_t req);
    out_beat_t ans;
    ans.found  = 1'b0;
    ans.status = ST_OK;
    case (req.req_type)
      REQ_ADD: begin
        // range check wins over the full check
        if (req.value == 0 || req.value > MAX_VALUE) begin
          ans.status = ST_RANGE;
        end else if (n_loaded >= MAX_ITEMS) begin
          ans.status = ST_FULL;
        end else begin
          sum_map = sum_map | (sum_map << req.value);
          n_loaded++;
          loaded_vals.push_back(32'(req.value));
        end
      end
      REQ_QUERY: begin
        if (req.value == 0 || req.value > MAX_SUM) ans.status = ST_RANGE;
        else ans.found = sum_map[req.value];
      end
      REQ_CLEAR: begin
        sum_map    = '0;
        sum_map[0] = 1'b1;
        n_loaded   = 0;
        loaded_vals.delete();
      end
      default: ;  // unused code: no state change, all-zero answer
    endcase
    return ans;
  endfunction

  // One request beat. Entered and left just after a falling edge; valid is
  // dropped only for idle cycles, so back-to-back beats keep it high.
  task automatic send_request(req_e rt, int unsigned v);
    in_beat_t beat;
    beat.req_type = rt;
    beat.value    = VALUE_W'(v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(predict_answer(beat));
    if (rt != REQ_NONE) useful_sent++;
    @(negedge clk);
  endtask

  function automatic int unsigned pick_add_value(bit force_max);
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return $urandom_range(65535, MAX_VALUE + 1);
    if (r == 1) return 0;
    if (force_max || r == 2) return MAX_VALUE;
    if (r == 3) return 1;
    if (r < 12) return $urandom_range(64, 1);
    return $urandom_range(MAX_VALUE, 1);
  endfunction

  // Mostly subset sums of what is loaded (hits), their neighbors (near
  // misses), and some wide random targets and edges. Only the low 16 bits
  // reach the port.
  function automatic int unsigned pick_target();
    int unsigned r;
    int          s;
    r = $urandom_range(9);
    s = 0;
    if (r < 5) begin
      foreach (loaded_vals[j]) if ($urandom_range(1)) s += loaded_vals[j];
      if (s == 0 && loaded_vals.size() > 0) s = loaded_vals[0];
      if (r == 4) s = $urandom_range(1) ? s + 1 : s - 1;
      return unsigned'(s);
    end
    if (r < 7) return $urandom_range(65535, 1);
    if (r == 7) return $urandom_range(300, 1);
    if (r == 8) begin
      foreach (loaded_vals[j]) s += loaded_vals[j];
      return unsigned'(s);
    end
    case ($urandom_range(2))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return MAX_ITEMS * MAX_VALUE;
    endcase
  endfunction

  task automatic send_noise();
    if ($urandom_range(1)) send_request(REQ_NONE, $urandom);
    else send_request(req_e'($urandom_range(3)), $urandom);
  endtask

  // clear, a run of adds, then queries; a fill run loads the set to the
  // limit and then pokes it with a bad value and a rejected add
  task automatic run_sequence(bit fill);
    int unsigned n_adds;
    int unsigned n_q;
    bit          all_max;
    send_request(REQ_CLEAR, $urandom);
    all_max = fill && $urandom_range(1);
    if (fill) begin
      while (n_loaded < MAX_ITEMS) begin
        if ($urandom_range(19) == 0) send_request(REQ_NONE, $urandom);
        send_request(REQ_ADD, pick_add_value(all_max));
      end
      send_request(REQ_ADD, 0);
      send_request(REQ_ADD, $urandom_range(MAX_VALUE, 1));
    end else begin
      n_adds = $urandom_range(8, 1);
      repeat (n_adds) begin
        if ($urandom_range(19) == 0) send_noise();
        send_request(REQ_ADD, pick_add_value(1'b0));
      end
    end
    n_q = $urandom_range(12, 3);
    repeat (n_q) begin
      if ($urandom_range(24) == 0) send_noise();
      send_request(REQ_QUERY, pick_target());
    end
  endtask

  task automatic test_reset_state();
    send_request(REQ_QUERY, 1);
    send_request(REQ_QUERY, 16'hFFFF);
    send_request(REQ_QUERY, 0);
  endtask

  task automatic test_range_edges();
    send_request(REQ_ADD, 0);
    send_request(REQ_ADD, MAX_VALUE + 1);
    send_request(REQ_ADD, 16'hFFFF);
    send_request(REQ_ADD, 16'hAAAA);
    send_request(REQ_ADD, 16'h5555);
  endtask

  task automatic test_add_query();
    send_request(REQ_ADD, 1);
    send_request(REQ_ADD, MAX_VALUE);
    send_request(REQ_QUERY, 1);
    send_request(REQ_QUERY, MAX_VALUE);
    send_request(REQ_QUERY, MAX_VALUE + 1);
    send_request(REQ_QUERY, 2);
    send_request(REQ_QUERY, MAX_VALUE - 1);
  endtask

  task automatic test_ignored_and_clear();
    send_request(REQ_NONE, 16'hFFFF);
    send_request(REQ_NONE, 0);
    send_request(REQ_QUERY, MAX_VALUE + 1);
    send_request(REQ_CLEAR, 0);
    send_request(REQ_QUERY, MAX_VALUE + 1);
    send_request(REQ_QUERY, 1);
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned n_items);
    int unsigned start;
    int unsigned seq_idx;
    start          = useful_sent;
    seq_idx        = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (useful_sent - start < n_items) begin
      run_sequence(seq_idx == 1);
      seq_idx++;
    end
  endtask

  // Receiver side: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each result beat against the oldest expected answer.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: found=%0b status=%0d",
                   out_data.found, out_data.status);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.found !== want.found || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected found=%0b status=%0d, got found=%0b status=%0d",
                     want.found, want.status, out_data.found, out_data.status);
        end
      end
    end
  end

  // Watchdog: a stretch with no beat on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    useful_sent    = 0;
    quiet_cycles   = 0;
    sum_map        = '0;
    sum_map[0]     = 1'b1;
    n_loaded       = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_range_edges();
    test_add_query();
    test_ignored_and_clear();

    test_random_phase(0, 0, 100);
    test_random_phase(47, 0, 100);
    test_random_phase(0, 47, 100);
    test_random_phase(7, 7, 100);

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ssq_pkg.sv
src/ssq_ram.sv
src/ssq_datapath.sv
src/ssq_ctrl.sv
src/subset_sum_query_core.sv
src/ssq_checker.sv
tb/sv/tb_subset_sum_query_core.sv
